// File: src/ddm_pkg.sv
// ---------------------------------------------------------------------------
// ddm_pkg: shared types and constants of the differential drive mixer
// Q1.14 formats, register indexes, item and mode codes, clamp helpers.
// ---------------------------------------------------------------------------
package ddm_pkg;

	localparam int Q_FRAC       = 14;
	localparam int Q_ONE        = 1 << Q_FRAC;
	localparam int PWM_BITS_DEF = 8;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [15:0] DEADMAN_RST  = 16'd300;
	localparam logic [15:0] TURN_GAIN_RST = 16'd16384;
	localparam logic [7:0]  PWM_FLOOR_RST = 8'd0;
	localparam logic [14:0] DEADBAND_RST  = 15'd164;

	localparam logic FUNC_CMD  = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEADMAN   = 2'd0,
		REG_TURN_GAIN = 2'd1,
		REG_PWM_FLOOR = 2'd2,
		REG_DEADBAND  = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_ACTIVE  = 2'd0,
		MODE_TIMEOUT = 2'd1,
		MODE_ESTOP   = 2'd2
	} mode_t;

	function automatic logic signed [18:0] sx19(input logic signed [15:0] v);
		return {{3{v[15]}}, v};
	endfunction

	function automatic logic signed [15:0] clamp_q(input logic signed [18:0] v);
		logic signed [18:0] hi;
		logic signed [18:0] lo;
		hi = 19'sd16384;
		lo = -19'sd16384;
		if (v > hi) begin
			return 16'sd16384;
		end else if (v < lo) begin
			return -16'sd16384;
		end
		return v[15:0];
	endfunction

	function automatic logic [14:0] mag_q(input logic signed [15:0] v);
		logic [15:0] n;
		n = -v;
		return v[15] ? n[14:0] : v[14:0];
	endfunction

endpackage

// File: src/ddm_if.sv
// ---------------------------------------------------------------------------
// ddm channel interfaces
// Command/tick input, result output and register write channels.
// ---------------------------------------------------------------------------
interface ddm_cmd_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic signed [15:0] throttle_cmd;
	logic signed [15:0] turn_cmd;
	logic               estop_req;
	logic               clear_req;

	modport source (output valid, func, throttle_cmd, turn_cmd, estop_req, clear_req,
		input ready);
	modport sink (input valid, func, throttle_cmd, turn_cmd, estop_req, clear_req,
		output ready);
endinterface

interface ddm_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] left_duty;
	logic       left_forward;
	logic [7:0] right_duty;
	logic       right_forward;
	logic [1:0] drive_mode;
	logic       latched_now;
	logic       cleared_now;

	modport source (output valid, left_duty, left_forward, right_duty, right_forward,
		drive_mode, latched_now, cleared_now, input ready);
	modport sink (input valid, left_duty, left_forward, right_duty, right_forward,
		drive_mode, latched_now, cleared_now, output ready);
endinterface

interface ddm_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [ddm_pkg::CFG_IDX_W-1:0]  index;
	logic [ddm_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: src/diff_drive_mixer_with_estop_deadman.sv
// ---------------------------------------------------------------------------
// diff_drive_mixer_with_estop_deadman
// Arcade-drive mixer for two wheels with e-stop latch and deadman timer.
// ---------------------------------------------------------------------------
// Takes one command or tick beat per clock while the pipeline is not full and
// stalled, and returns one result beat for each, in order. The latch, counter
// and held command update at acceptance, then the turn-by-gain multiply, the
// wheel mix and the PWM scaling each take one register stage before the result
// leaves the output register. Every stage holds only while the stage after
// it is full and stalled, so a waiting result does not block new beats
// while any stage is empty. Register writes are taken in any cycle.
// ---------------------------------------------------------------------------
module diff_drive_mixer_with_estop_deadman #(
	parameter int PWM_BITS = ddm_pkg::PWM_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ddm_cmd_if.sink    cmd,
	ddm_res_if.source  res,
	ddm_cfg_if.sink    cfg
);
	import ddm_pkg::*;

	localparam int MW = 15 + PWM_BITS;
	localparam int CW = (PWM_BITS > 8) ? PWM_BITS : 8;
	localparam logic [CW-1:0] PwmMax = CW'((1 << PWM_BITS) - 1);

	logic [15:0] deadman_q;
	logic [15:0] turn_gain_q;
	logic [7:0]  pwm_floor_q;
	logic [14:0] deadband_q;

	logic               estop_q;
	logic [15:0]        ms_q;
	logic signed [15:0] held_t_q;
	logic signed [15:0] held_r_q;

	logic               valid_s1, valid_s2, valid_s3, valid_s4;
	logic               en_s1, en_s2, en_s3, en_s4;
	logic               cmd_acc;

	logic signed [15:0] t_in, r_in;
	logic               latch_set, clear_ok, estop_nx;
	logic [15:0]        ms_nx;
	logic signed [15:0] held_t_nx, held_r_nx;
	mode_t              mode_nx;

	mode_t              mode_s1, mode_s2, mode_s3;
	logic signed [15:0] t_s1, r_s1, t_s2;
	logic               latched_s1, latched_s2, latched_s3;
	logic               cleared_s1, cleared_s2, cleared_s3;
	logic signed [32:0] prod_s2;
	logic signed [15:0] left_s3, right_s3;

	logic signed [32:0] prod_adj;
	logic signed [15:0] r_scaled;
	logic signed [15:0] left_mix, right_mix;

	logic [7:0] left_duty_s4, right_duty_s4;
	logic       left_fwd_s4, right_fwd_s4;
	logic [1:0] mode_s4;
	logic       latched_s4, cleared_s4;

	function automatic logic [7:0] duty_of(input logic signed [15:0] x,
		input logic [7:0] floor_v);
		logic [14:0]   m;
		logic [MW-1:0] scaled;
		logic [CW-1:0] pwm;
		m = mag_q(x);
		scaled = (MW'(m) << PWM_BITS) - MW'(m);
		pwm = CW'(scaled >> Q_FRAC);
		if (pwm != '0 && pwm < CW'(floor_v)) begin
			pwm = CW'(floor_v);
		end
		if (pwm > PwmMax) begin
			pwm = PwmMax;
		end
		return pwm[7:0];
	endfunction

	// register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadman_q   <= DEADMAN_RST;
			turn_gain_q <= TURN_GAIN_RST;
			pwm_floor_q <= PWM_FLOOR_RST;
			deadband_q  <= DEADBAND_RST;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_DEADMAN:   deadman_q   <= cfg.data;
				REG_TURN_GAIN: turn_gain_q <= cfg.data;
				REG_PWM_FLOOR: pwm_floor_q <= cfg.data[7:0];
				REG_DEADBAND:  deadband_q  <= cfg.data[14:0];
				default:       deadman_q   <= deadman_q;
			endcase
		end
	end

	// stage handshake
	assign en_s4 = !valid_s4 || res.ready;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;
	assign cmd.ready = en_s1;
	assign cmd_acc = cmd.valid && en_s1;

	// state update on acceptance
	always_comb begin
		t_in = clamp_q(sx19(cmd.throttle_cmd));
		r_in = clamp_q(sx19(cmd.turn_cmd));
		latch_set = 1'b0;
		clear_ok = 1'b0;
		estop_nx = estop_q;
		held_t_nx = held_t_q;
		held_r_nx = held_r_q;
		ms_nx = ms_q;
		if (cmd.func == FUNC_CMD) begin
			latch_set = cmd.estop_req;
			clear_ok = (estop_q || cmd.estop_req) && cmd.clear_req &&
				(mag_q(t_in) < deadband_q) && (mag_q(r_in) < deadband_q);
			estop_nx = (estop_q || cmd.estop_req) && !clear_ok;
			held_t_nx = t_in;
			held_r_nx = r_in;
			ms_nx = '0;
		end else if (ms_q != 16'hFFFF) begin
			ms_nx = ms_q + 16'd1;
		end
		if (estop_nx) begin
			mode_nx = MODE_ESTOP;
		end else if (ms_nx > deadman_q) begin
			mode_nx = MODE_TIMEOUT;
		end else begin
			mode_nx = MODE_ACTIVE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			estop_q  <= 1'b0;
			ms_q     <= '0;
			held_t_q <= '0;
			held_r_q <= '0;
		end else if (cmd_acc) begin
			estop_q  <= estop_nx;
			ms_q     <= ms_nx;
			held_t_q <= held_t_nx;
			held_r_q <= held_r_nx;
		end
	end

	// mix arithmetic
	always_comb begin
		prod_adj = prod_s2 + (prod_s2[32] ? 33'sd16383 : 33'sd0);
		r_scaled = clamp_q(prod_adj[32:14]);
		left_mix = clamp_q(sx19(t_s2) + sx19(r_scaled));
		right_mix = clamp_q(sx19(t_s2) - sx19(r_scaled));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= cmd_acc;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
			if (en_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			mode_s1    <= mode_nx;
			t_s1       <= held_t_nx;
			r_s1       <= held_r_nx;
			latched_s1 <= (cmd.func == FUNC_CMD) && latch_set;
			cleared_s1 <= clear_ok;
		end
		if (en_s2) begin
			mode_s2    <= mode_s1;
			t_s2       <= t_s1;
			prod_s2    <= r_s1 * $signed({1'b0, turn_gain_q});
			latched_s2 <= latched_s1;
			cleared_s2 <= cleared_s1;
		end
		if (en_s3) begin
			mode_s3    <= mode_s2;
			left_s3    <= left_mix;
			right_s3   <= right_mix;
			latched_s3 <= latched_s2;
			cleared_s3 <= cleared_s2;
		end
		if (en_s4) begin
			mode_s4    <= mode_s3;
			latched_s4 <= latched_s3;
			cleared_s4 <= cleared_s3;
			if (mode_s3 == MODE_ACTIVE) begin
				left_duty_s4  <= duty_of(left_s3, pwm_floor_q);
				right_duty_s4 <= duty_of(right_s3, pwm_floor_q);
				left_fwd_s4   <= !left_s3[15];
				right_fwd_s4  <= !right_s3[15];
			end else begin
				left_duty_s4  <= '0;
				right_duty_s4 <= '0;
				left_fwd_s4   <= 1'b0;
				right_fwd_s4  <= 1'b0;
			end
		end
	end

	assign res.valid         = valid_s4;
	assign res.left_duty     = left_duty_s4;
	assign res.left_forward  = left_fwd_s4;
	assign res.right_duty    = right_duty_s4;
	assign res.right_forward = right_fwd_s4;
	assign res.drive_mode    = mode_s4;
	assign res.latched_now   = latched_s4;
	assign res.cleared_now   = cleared_s4;

	a_latch_mode: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.latched_now && !res.cleared_now |-> res.drive_mode == MODE_ESTOP)
		else $error("latching result not in e-stop mode");

	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.drive_mode != MODE_ACTIVE |->
		res.left_duty == '0 && res.right_duty == '0 && !res.left_forward &&
		!res.right_forward)
		else $error("stopped result drives a wheel");

	a_tick_keeps_latch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc && cmd.func == FUNC_TICK |=> estop_q == $past(estop_q))
		else $error("tick changed the e-stop latch");

	a_ms_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc && cmd.func == FUNC_TICK && ms_q == 16'hFFFF |=> ms_q == 16'hFFFF)
		else $error("millisecond counter wrapped");

	a_cleared_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && cleared_s1 |-> !$past(estop_nx) || !$past(cmd_acc))
		else $error("clear reported while latch stays set");

endmodule

// File: verif/ddm_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ddm_checker: result predictor and scoreboard for the drive mixer
// Watches the command, result and register channels, tracks latch, idle
// counter, held command and registers, predicts each result beat and
// compares it field by field against the next one out of the block.
// ---------------------------------------------------------------------------
module ddm_checker
	import ddm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	ddm_cmd_if   cmd,
	ddm_res_if   res,
	ddm_cfg_if   cfg,
	output int   errors,
	output int   results
);

	localparam int PWM_MAX = (1 << PWM_BITS_DEF) - 1;

	typedef struct packed {
		logic [7:0] left_duty;
		logic       left_fwd;
		logic [7:0] right_duty;
		logic       right_fwd;
		mode_t      mode;
		logic       latched;
		logic       cleared;
	} drive_out_t;

	drive_out_t drive_q[$];
	drive_out_t want;
	drive_out_t got;

	logic               estop_on;
	logic [15:0]        ms_idle;
	logic signed [15:0] hold_thr;
	logic signed [15:0] hold_turn;

	logic [15:0] deadman_lim;
	logic [15:0] gain;
	logic [7:0]  floor_duty;
	logic [14:0] deadband;

	int err_cnt = 0;
	int res_cnt = 0;

	assign errors  = err_cnt;
	assign results = res_cnt;

	function automatic logic signed [15:0] sat_q(input longint v);
		if (v > Q_ONE) begin
			return 16'sd16384;
		end else if (v < -Q_ONE) begin
			return -16'sd16384;
		end
		return v[15:0];
	endfunction

	function automatic int magnitude(input logic signed [15:0] v);
		return (v < 0) ? -int'(v) : int'(v);
	endfunction

	function automatic void wheel_pwm(input logic signed [15:0] x, output logic [7:0] duty,
		output logic fwd);
		int p;
		p = magnitude(x) * PWM_MAX / Q_ONE;
		if (p > 0 && p < int'(floor_duty)) begin
			p = int'(floor_duty);
		end
		if (p > PWM_MAX) begin
			p = PWM_MAX;
		end
		duty = p[7:0];
		fwd = (x >= 0);
	endfunction

	function automatic drive_out_t step_drive(input logic fn, input logic signed [15:0] thr,
		input logic signed [15:0] trn, input logic est, input logic clr);
		drive_out_t         o;
		logic signed [15:0] t;
		logic signed [15:0] r;
		logic signed [15:0] mix_r;
		logic signed [15:0] lw;
		logic signed [15:0] rw;
		logic [7:0]         d;
		logic               f;
		longint             prod;
		o = '0;
		if (fn == FUNC_CMD) begin
			t = sat_q(longint'(thr));
			r = sat_q(longint'(trn));
			if (est) begin
				estop_on = 1'b1;
				o.latched = 1'b1;
			end
			if (estop_on && clr && magnitude(t) < int'(deadband)
				&& magnitude(r) < int'(deadband)) begin
				estop_on = 1'b0;
				o.cleared = 1'b1;
			end
			hold_thr = t;
			hold_turn = r;
			ms_idle = '0;
		end else if (ms_idle != 16'hFFFF) begin
			ms_idle = ms_idle + 16'd1;
		end
		if (estop_on || ms_idle > deadman_lim) begin
			o.mode = estop_on ? MODE_ESTOP : MODE_TIMEOUT;
		end else begin
			prod = longint'(hold_turn) * longint'(gain);
			mix_r = sat_q(prod / Q_ONE);
			lw = sat_q(longint'(hold_thr) + longint'(mix_r));
			rw = sat_q(longint'(hold_thr) - longint'(mix_r));
			wheel_pwm(lw, d, f);
			o.left_duty = d;
			o.left_fwd = f;
			wheel_pwm(rw, d, f);
			o.right_duty = d;
			o.right_fwd = f;
			o.mode = MODE_ACTIVE;
		end
		return o;
	endfunction

	task automatic check_field(input string name, input logic [7:0] exp_v,
		input logic [7:0] act_v);
		if (act_v !== exp_v) begin
			err_cnt++;
			if (err_cnt <= 40) begin
				$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name,
					exp_v, act_v);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			estop_on = 1'b0;
			ms_idle = '0;
			hold_thr = '0;
			hold_turn = '0;
			deadman_lim = DEADMAN_RST;
			gain = TURN_GAIN_RST;
			floor_duty = PWM_FLOOR_RST;
			deadband = DEADBAND_RST;
			drive_q.delete();
		end else begin
			if (res.valid && res.ready) begin
				res_cnt++;
				got.left_duty = res.left_duty;
				got.left_fwd = res.left_forward;
				got.right_duty = res.right_duty;
				got.right_fwd = res.right_forward;
				got.mode = mode_t'(res.drive_mode);
				got.latched = res.latched_now;
				got.cleared = res.cleared_now;
				if (drive_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 40) begin
						$display("%0t ns: result beat with none expected, actual %p",
							$time, got);
					end
				end else begin
					want = drive_q.pop_front();
					check_field("left_duty", want.left_duty, res.left_duty);
					check_field("left_forward", 8'(want.left_fwd), 8'(res.left_forward));
					check_field("right_duty", want.right_duty, res.right_duty);
					check_field("right_forward", 8'(want.right_fwd),
						8'(res.right_forward));
					check_field("drive_mode", 8'(want.mode), 8'(res.drive_mode));
					check_field("latched_now", 8'(want.latched), 8'(res.latched_now));
					check_field("cleared_now", 8'(want.cleared), 8'(res.cleared_now));
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (reg_idx_t'(cfg.index))
					REG_DEADMAN: begin
						deadman_lim = cfg.data;
					end
					REG_TURN_GAIN: begin
						gain = cfg.data;
					end
					REG_PWM_FLOOR: begin
						floor_duty = cfg.data[7:0];
					end
					REG_DEADBAND: begin
						deadband = cfg.data[14:0];
					end
					default: begin
					end
				endcase
			end
			if (cmd.valid && cmd.ready) begin
				drive_q.push_back(step_drive(cmd.func, cmd.throttle_cmd, cmd.turn_cmd,
					cmd.estop_req, cmd.clear_req));
			end
		end
	end

endmodule

// File: verif/diff_drive_mixer_with_estop_deadman_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// diff_drive_mixer_with_estop_deadman_tb: stimulus and verdict
// Drives commands and ticks with random gaps and output stalls across
// several register settings, including the extremes, a long output stall
// and a drain pause after each setting.
// ---------------------------------------------------------------------------
module diff_drive_mixer_with_estop_deadman_tb;
	import ddm_pkg::*;

	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 4000;

	logic clk;
	logic arst_n;

	ddm_cmd_if cmd();
	ddm_res_if res();
	ddm_cfg_if cfg();

	int chk_errors;
	int chk_results;

	int n_sent = 0;
	int n_cmds = 0;
	int n_ticks = 0;
	int n_settings = 1;
	int stall_cycles = 0;

	logic        calm = 1'b0;
	logic        hold_req = 1'b0;
	int          cur_deadman = int'(DEADMAN_RST);
	int          cur_deadband = int'(DEADBAND_RST);

	diff_drive_mixer_with_estop_deadman DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (res),
		.cfg    (cfg)
	);

	ddm_checker mixer_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.res     (res),
		.cfg     (cfg),
		.errors  (chk_errors),
		.results (chk_results)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 9) == 0) begin
			return $urandom_range(10, 40);
		end
		return $urandom_range(1, 3);
	endfunction

	function automatic logic signed [15:0] rand_q();
		int sel;
		int v;
		sel = $urandom_range(0, 99);
		if (sel < 55) begin
			v = int'($urandom_range(0, 32768)) - 16384;
		end else if (sel < 75) begin
			v = $urandom;
		end else if (sel < 90) begin
			v = int'($urandom_range(0, 400)) - 200;
		end else begin
			case ($urandom_range(0, 4))
				0: v = 16384;
				1: v = -16384;
				2: v = 0;
				3: v = 32767;
				default: v = -32768;
			endcase
		end
		return v[15:0];
	endfunction

	function automatic logic signed [15:0] near_band();
		int m;
		m = $urandom_range(0, cur_deadband);
		return ($urandom_range(0, 1) == 1) ? 16'(-m) : 16'(m);
	endfunction

	task automatic send_beat(input logic fn, input logic signed [15:0] thr,
		input logic signed [15:0] trn, input logic est, input logic clr);
		int n;
		cmd.valid <= 1'b1;
		cmd.func <= fn;
		cmd.throttle_cmd <= thr;
		cmd.turn_cmd <= trn;
		cmd.estop_req <= est;
		cmd.clear_req <= clr;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		n_sent++;
		if (fn == FUNC_CMD) begin
			n_cmds++;
		end else begin
			n_ticks++;
		end
		n = (calm || $urandom_range(0, 99) < 60) ? 0 : gap_len();
		if (n > 0) begin
			cmd.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_tick();
		send_beat(FUNC_TICK, 16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
	endtask

	task automatic put_reg(input reg_idx_t idx, input logic [15:0] v);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= v;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
	endtask

	task automatic program_regs(input int dm, input int g, input int fl, input int db);
		put_reg(REG_DEADMAN, 16'(dm));
		put_reg(REG_TURN_GAIN, 16'(g));
		put_reg(REG_PWM_FLOOR, 16'(fl));
		put_reg(REG_DEADBAND, 16'(db));
		cfg.valid <= 1'b0;
		cur_deadman = dm;
		cur_deadband = db;
		n_settings++;
	endtask

	task automatic drain();
		cmd.valid <= 1'b0;
		wait (chk_results >= n_sent);
	endtask

	task automatic random_beats(input int n);
		int left_n;
		int sel;
		int burst;
		left_n = n;
		while (left_n > 0) begin
			sel = $urandom_range(0, 99);
			if (sel < 3 && cur_deadman <= 400 && cur_deadman + 5 < left_n) begin
				burst = cur_deadman + $urandom_range(1, 4);
				send_beat(FUNC_CMD, rand_q(), rand_q(), 1'b0, 1'b0);
				repeat (burst) send_tick();
				left_n -= burst;
			end else if (sel < 30) begin
				send_tick();
			end else if (sel < 38) begin
				send_beat(FUNC_CMD, rand_q(), rand_q(), 1'b1, $urandom_range(0, 3) == 0);
			end else if (sel < 52) begin
				send_beat(FUNC_CMD, near_band(), near_band(), $urandom_range(0, 4) == 0,
					1'b1);
			end else begin
				send_beat(FUNC_CMD, rand_q(), rand_q(), $urandom_range(0, 99) < 3,
					$urandom_range(0, 99) < 5);
			end
			left_n--;
		end
	endtask

	initial begin
		res.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				res.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (calm || $urandom_range(0, 99) < 65) begin
				res.ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				res.ready <= 1'b0;
				repeat (gap_len()) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd.valid && cmd.ready) || (res.valid && res.ready)
				|| (cfg.valid && cfg.ready)) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
				if (stall_cycles >= WATCHDOG_LIMIT) begin
					$display("Verification failed");
					$finish;
				end
			end
		end
	end

	initial begin
		cmd.valid <= 1'b0;
		cmd.func <= FUNC_CMD;
		cmd.throttle_cmd <= '0;
		cmd.turn_cmd <= '0;
		cmd.estop_req <= 1'b0;
		cmd.clear_req <= 1'b0;
		cfg.valid <= 1'b0;
		cfg.index <= REG_DEADMAN;
		cfg.data <= '0;
		wait (arst_n === 1'b1);
		@(posedge clk);

		send_beat(FUNC_CMD, 16'sd16384, 16'sd0, 1'b0, 1'b0);
		send_beat(FUNC_CMD, -16'sd16384, 16'sd16384, 1'b0, 1'b0);
		send_beat(FUNC_CMD, 16'sh7FFF, 16'sh8000, 1'b0, 1'b0);
		send_beat(FUNC_CMD, 16'sh8000, 16'sh7FFF, 1'b0, 1'b0);
		send_beat(FUNC_CMD, 16'sd0, 16'sd0, 1'b0, 1'b0);
		send_beat(FUNC_CMD, -16'sd1, 16'sd1, 1'b0, 1'b0);
		send_beat(FUNC_TICK, 16'sh7FFF, 16'sh8000, 1'b1, 1'b1);
		send_beat(FUNC_CMD, 16'sd4000, -16'sd2500, 1'b0, 1'b1);
		send_beat(FUNC_CMD, 16'sd100, 16'sd50, 1'b1, 1'b0);
		send_beat(FUNC_CMD, 16'sd100, 16'sd50, 1'b1, 1'b0);
		send_beat(FUNC_TICK, 16'sd0, 16'sd0, 1'b0, 1'b0);
		send_beat(FUNC_CMD, 16'sd164, 16'sd0, 1'b0, 1'b1);
		send_beat(FUNC_CMD, 16'sd0, -16'sd164, 1'b0, 1'b1);
		send_beat(FUNC_CMD, 16'sd20000, 16'sd0, 1'b0, 1'b1);
		send_beat(FUNC_CMD, 16'sd163, -16'sd163, 1'b0, 1'b1);
		send_beat(FUNC_CMD, -16'sd10, 16'sd10, 1'b1, 1'b1);
		send_beat(FUNC_CMD, 16'sd8192, 16'sd8192, 1'b0, 1'b0);
		send_beat(FUNC_CMD, 16'sh8000, 16'sh8000, 1'b1, 1'b1);
		send_beat(FUNC_CMD, 16'sd0, 16'sd0, 1'b0, 1'b1);
		random_beats(100);
		drain();

		program_regs(0, 0, 255, 0);
		random_beats(110);
		drain();

		program_regs(65535, 65535, 1, 16384);
		random_beats(55);
		drain();
		random_beats(55);
		drain();

		program_regs(3, 32768, 128, 2000);
		hold_req = 1'b1;
		random_beats(110);
		drain();

		repeat (5) begin
			program_regs(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
				: $urandom_range(0, 12),
				($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
				: $urandom_range(0, 32768),
				$urandom_range(0, 255), $urandom_range(0, 16384));
			calm = ($urandom_range(0, 2) == 0);
			random_beats(40);
			calm = 1'b0;
			random_beats(70);
			drain();
		end

		repeat (12) @(posedge clk);
		$display("Covered %0d commands and %0d ticks under %0d register settings,",
			n_cmds, n_ticks, n_settings);
		$display("incl. e-stop latch/release and deadman expiry;"
			, " %0d results checked.", chk_results);
		if (chk_errors == 0 && chk_results == n_sent) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
